>>> design/ang_pkg.sv
package ang_pkg;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 8;
    localparam int GAIN_W   = 9;
    localparam int STEP_W   = 9;
    localparam int THRESH_W = 15;
    localparam int COUNT_W  = 24;

    // Shared multiplier: 24 x 32 bits, product registered
    localparam int MUL_A_W     = 24;
    localparam int MUL_B_W     = 32;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 32;

    // APB port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int IDX_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // Register index, byte address is 4 * index
    typedef enum logic [IDX_W-1:0] {
        REG_AUTO_MUTE = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_HOLD      = 3'd2,
        REG_FADE_IN   = 3'd3,
        REG_FADE_OUT  = 3'd4
    } ang_reg_idx_t;

    typedef struct packed {
        logic                auto_mute_enable;
        logic [THRESH_W-1:0] silence_threshold;
        logic [COUNT_W-1:0]  hold_samples;
        logic [STEP_W-1:0]   fade_in_step;
        logic [STEP_W-1:0]   fade_out_step;
    } ang_cfg_t;

    localparam ang_cfg_t CFG_RESET = '{
        auto_mute_enable:  1'b1,
        silence_threshold: 15'd64,
        hold_samples:      24'd8000,
        fade_in_step:      9'd256,
        fade_out_step:     9'd256
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_CHECK,
        ST_FETCH,
        ST_MUL1,
        ST_MUL2,
        ST_FIN,
        ST_SEND
    } ang_state_t;

endpackage

>>> design/ang_cfg.sv
module ang_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ang_pkg::APB_AW-1:0]  paddr,
    input  logic [ang_pkg::APB_DW-1:0]  pwdata,
    output logic [ang_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output ang_pkg::ang_cfg_t           cfg
);

    ang_pkg::ang_cfg_t               cfg_reg;
    logic                            wr_en;
    logic [ang_pkg::IDX_W-1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ang_pkg::APB_AW-1:2];
    assign cfg     = cfg_reg;

    // register writes, values masked to their width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ang_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ang_pkg::REG_AUTO_MUTE: cfg_reg.auto_mute_enable  <= pwdata[0];
                ang_pkg::REG_THRESHOLD: cfg_reg.silence_threshold <= pwdata[ang_pkg::THRESH_W-1:0];
                ang_pkg::REG_HOLD:      cfg_reg.hold_samples      <= pwdata[ang_pkg::COUNT_W-1:0];
                ang_pkg::REG_FADE_IN:   cfg_reg.fade_in_step      <= pwdata[ang_pkg::STEP_W-1:0];
                ang_pkg::REG_FADE_OUT:  cfg_reg.fade_out_step     <= pwdata[ang_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            ang_pkg::REG_AUTO_MUTE: prdata[0] = cfg_reg.auto_mute_enable;
            ang_pkg::REG_THRESHOLD: prdata[ang_pkg::THRESH_W-1:0] = cfg_reg.silence_threshold;
            ang_pkg::REG_HOLD:      prdata[ang_pkg::COUNT_W-1:0]  = cfg_reg.hold_samples;
            ang_pkg::REG_FADE_IN:   prdata[ang_pkg::STEP_W-1:0]   = cfg_reg.fade_in_step;
            ang_pkg::REG_FADE_OUT:  prdata[ang_pkg::STEP_W-1:0]   = cfg_reg.fade_out_step;
            default: ;
        endcase
    end

endmodule

>>> design/ang_mul.sv
module ang_mul (
    input  logic                         clk,
    input  logic [ang_pkg::MUL_A_W-1:0]  a,
    input  logic [ang_pkg::MUL_B_W-1:0]  b,
    output logic [ang_pkg::MUL_P_W-1:0]  p
);

    logic [ang_pkg::MUL_P_W-1:0] p_reg;

    // unsigned product, registered
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> design/ang_core.sv
module ang_core #(
    parameter int CHUNK_SAMPLES = 32,
    parameter int GAIN_MAX      = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ang_pkg::ang_cfg_t             cfg,
    // sample input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ang_pkg::SAMPLE_W-1:0]  in_sample,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ang_pkg::CODE_W-1:0]    out_code,
    output logic [ang_pkg::SAMPLE_W-1:0]  out_gated,
    output logic                          out_drive,
    output logic                          out_last,
    // shared multiplier
    output logic [ang_pkg::MUL_A_W-1:0]   mul_a,
    output logic [ang_pkg::MUL_B_W-1:0]   mul_b,
    input  logic [ang_pkg::MUL_P_W-1:0]   mul_p
);

    localparam int FILL_W = $clog2(CHUNK_SAMPLES);
    localparam int DEPTH  = 2 * CHUNK_SAMPLES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W1 = ang_pkg::COUNT_W + 1;
    localparam int GSUM_W = ang_pkg::GAIN_W + 1;
    localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(CHUNK_SAMPLES - 1);
    localparam logic [ADDR_W-1:0] SLOT1_BASE = ADDR_W'(CHUNK_SAMPLES);
    localparam logic [CNT_W1-1:0] CHUNK_CNT = CNT_W1'(CHUNK_SAMPLES);
    localparam logic [ang_pkg::GAIN_W-1:0] GAIN_FULL = ang_pkg::GAIN_W'(GAIN_MAX);
    // reciprocal of GAIN_MAX, exact floor division for products below 2^24
    localparam logic [ang_pkg::MUL_B_W-1:0] RECIP =
        ang_pkg::MUL_B_W'((64'd1 << ang_pkg::RECIP_SHIFT) / GAIN_MAX + 1);

    ang_pkg::ang_state_t state_reg, state_next;

    logic [ang_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
    logic [ang_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic                         slot_reg;
    logic                         primed_reg;
    logic [1:0]                   flag_reg;
    logic [ang_pkg::COUNT_W-1:0]  silence_reg, silence_next;
    logic [ang_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [ang_pkg::GAIN_W-1:0]   target_reg, target_next;
    logic                         drive_reg;
    logic [FILL_W-1:0]            idx_reg;
    logic [ang_pkg::SAMPLE_W-1:0] out_gated_reg;

    logic                         in_fire;
    logic                         chunk_done;
    logic [ang_pkg::SAMPLE_W-1:0] in_mag;
    logic                         in_sig;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         gate;
    logic                         has_sig;
    logic                         next_sig;
    logic [CNT_W1-1:0]            silence_sum;
    logic [ang_pkg::COUNT_W-1:0]  silence_inc;
    logic [GSUM_W-1:0]            up_sum;
    logic [ang_pkg::GAIN_W-1:0]   up_val;
    logic [ang_pkg::GAIN_W-1:0]   down_raw;
    logic [ang_pkg::GAIN_W-1:0]   down_val;
    logic [ang_pkg::GAIN_W-1:0]   gain_ramp;
    logic [ang_pkg::SAMPLE_W-1:0] rd_mag;
    logic [ang_pkg::SAMPLE_W-1:0] quot;
    logic                         drive_calc;

    // input side
    assign in_ready   = (state_reg == ang_pkg::ST_IDLE);
    assign in_fire    = in_valid & in_ready;
    assign chunk_done = in_fire && (fill_reg == LAST_POS);
    assign in_mag     = in_sample[ang_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign in_sig     = in_mag > {1'b0, cfg.silence_threshold};
    assign wr_addr    = slot_reg ? (SLOT1_BASE + ADDR_W'(fill_reg)) : ADDR_W'(fill_reg);

    // during a burst slot_reg already points at the chunk being emitted
    assign rd_addr  = slot_reg ? (SLOT1_BASE + ADDR_W'(idx_reg)) : ADDR_W'(idx_reg);
    assign gate     = cfg.auto_mute_enable;
    assign has_sig  = flag_reg[slot_reg];
    assign next_sig = flag_reg[~slot_reg];

    // chunk store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_mem[wr_addr] <= in_sample;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // saturating silence count
    assign silence_sum = {1'b0, silence_reg} + CHUNK_CNT;
    assign silence_inc = silence_sum[ang_pkg::COUNT_W] ? ang_pkg::COUNT_SAT
                                                       : silence_sum[ang_pkg::COUNT_W-1:0];

    // per-chunk gate target
    always_comb
    begin
        silence_next = silence_reg;
        target_next  = target_reg;
        if (state_reg == ang_pkg::ST_PLAN && gate)
        begin
            priority if (has_sig)
            begin
                silence_next = '0;
                target_next  = GAIN_FULL;
            end
            else if (next_sig)
            begin
                silence_next = '0;
                if (gain_reg != '0)
                begin
                    target_next = GAIN_FULL;
                end
            end
            else
            begin
                silence_next = silence_inc;
                target_next  = (silence_inc >= cfg.hold_samples) ? '0 : GAIN_FULL;
            end
        end
    end

    // per-sample gain ramp with clamping
    assign up_sum   = {1'b0, gain_reg} + {1'b0, cfg.fade_in_step};
    assign up_val   = (up_sum > {1'b0, target_reg}) ? target_reg : up_sum[ang_pkg::GAIN_W-1:0];
    assign down_raw = (gain_reg > cfg.fade_out_step) ? (gain_reg - cfg.fade_out_step) : '0;
    assign down_val = (down_raw < target_reg) ? target_reg : down_raw;

    always_comb
    begin
        priority if (gain_reg < target_reg)
            gain_ramp = up_val;
        else if (gain_reg > target_reg)
            gain_ramp = down_val;
        else
            gain_ramp = gain_reg;
    end

    assign gain_next = (state_reg == ang_pkg::ST_FETCH && gate) ? gain_ramp : gain_reg;

    // mute when the gain must reach zero within the chunk: gain <= fade_out_step * chunk
    assign drive_calc = !(gate && target_reg == '0 && !has_sig && !next_sig &&
                          ang_pkg::MUL_P_W'(gain_reg) <= mul_p);

    // sample magnitude and quotient
    assign rd_mag = rd_data_reg[ang_pkg::SAMPLE_W-1] ? (~rd_data_reg + 1'b1) : rd_data_reg;
    assign quot   = mul_p[ang_pkg::RECIP_SHIFT +: ang_pkg::SAMPLE_W];

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ang_pkg::ST_PLAN:
            begin
                mul_a = ang_pkg::MUL_A_W'(cfg.fade_out_step);
                mul_b = ang_pkg::MUL_B_W'(CHUNK_SAMPLES);
            end
            ang_pkg::ST_MUL1:
            begin
                mul_a = ang_pkg::MUL_A_W'(rd_mag);
                mul_b = ang_pkg::MUL_B_W'(gain_reg);
            end
            ang_pkg::ST_MUL2:
            begin
                mul_a = mul_p[ang_pkg::MUL_A_W-1:0];
                mul_b = RECIP;
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ang_pkg::ST_IDLE:  if (chunk_done && primed_reg) state_next = ang_pkg::ST_PLAN;
            ang_pkg::ST_PLAN:  state_next = ang_pkg::ST_CHECK;
            ang_pkg::ST_CHECK: state_next = ang_pkg::ST_FETCH;
            ang_pkg::ST_FETCH: state_next = ang_pkg::ST_MUL1;
            ang_pkg::ST_MUL1:  state_next = gate ? ang_pkg::ST_MUL2 : ang_pkg::ST_SEND;
            ang_pkg::ST_MUL2:  state_next = ang_pkg::ST_FIN;
            ang_pkg::ST_FIN:   state_next = ang_pkg::ST_SEND;
            ang_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = (idx_reg == LAST_POS) ? ang_pkg::ST_IDLE : ang_pkg::ST_FETCH;
                end
            end
            default: state_next = ang_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ang_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // chunk filling and gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            slot_reg    <= 1'b0;
            primed_reg  <= 1'b0;
            flag_reg    <= '0;
            silence_reg <= '0;
            gain_reg    <= '0;
            target_reg  <= '0;
            drive_reg   <= 1'b1;
            idx_reg     <= '0;
        end
        else
        begin
            silence_reg <= silence_next;
            gain_reg    <= gain_next;
            target_reg  <= target_next;
            if (in_fire)
            begin
                flag_reg[slot_reg] <= (fill_reg == '0) ? in_sig : (flag_reg[slot_reg] | in_sig);
                if (chunk_done)
                begin
                    fill_reg   <= '0;
                    slot_reg   <= ~slot_reg;
                    primed_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (state_reg == ang_pkg::ST_CHECK)
            begin
                drive_reg <= drive_calc;
                idx_reg   <= '0;
            end
            if (state_reg == ang_pkg::ST_SEND && out_ready && idx_reg != LAST_POS)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // result register, held while the beat waits
    always_ff @(posedge clk)
    begin
        if (state_reg == ang_pkg::ST_MUL1 && !gate)
        begin
            out_gated_reg <= rd_data_reg;
        end
        else if (state_reg == ang_pkg::ST_FIN)
        begin
            out_gated_reg <= rd_data_reg[ang_pkg::SAMPLE_W-1] ? (~quot + 1'b1) : quot;
        end
    end

    assign out_valid = (state_reg == ang_pkg::ST_SEND);
    assign out_gated = out_gated_reg;
    assign out_code  = {~out_gated_reg[ang_pkg::SAMPLE_W-1],
                        out_gated_reg[ang_pkg::SAMPLE_W-2 -: (ang_pkg::CODE_W-1)]};
    assign out_drive = drive_reg;
    assign out_last  = (idx_reg == LAST_POS);

endmodule

>>> design/audio_noise_gate_dac.sv
// Channel   Dir  Signals                               Beat contents
// s_*       in   s_tvalid s_tready s_tdata[15:0]        sample
// m_*       out  m_tvalid m_tready m_tdata m_tuser      dac_code, gated_sample, drive_on
//                m_tlast                                chunk_end in tlast
// apb       in   psel penable pwrite paddr pwdata       five registers at 4*index
//
// A sample is accepted whenever no burst is running. The completing sample of
// each chunk after the first starts a burst of CHUNK_SAMPLES beats: plan and check states,
// then per beat fetch, two multiply states, finish and send with gating on (the shared
// multiplier is used twice per sample) or fetch, multiply and send with gating off.
// Send waits for m_tready; s_tready is low for the whole burst. Reset is asynchronous,
// active low, and clears control state and registers; the chunk store needs no clearing.
module audio_noise_gate_dac #(
    parameter int CHUNK_SAMPLES = 32,
    parameter int GAIN_MAX      = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [7:0] dac_code, [23:8] gated_sample
    output logic [0:0]                  m_tuser,   // [0] drive_on
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ang_pkg::APB_AW-1:0]  paddr,
    input  logic [ang_pkg::APB_DW-1:0]  pwdata,
    output logic [ang_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    ang_pkg::ang_cfg_t               cfg;
    logic [ang_pkg::MUL_A_W-1:0]     mul_a;
    logic [ang_pkg::MUL_B_W-1:0]     mul_b;
    logic [ang_pkg::MUL_P_W-1:0]     mul_p;
    logic [ang_pkg::CODE_W-1:0]      out_code;
    logic [ang_pkg::SAMPLE_W-1:0]    out_gated;
    logic                            out_drive;

    // configuration registers
    ang_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared multiplier
    ang_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // chunk store and sequencer
    ang_core #(
        .CHUNK_SAMPLES (CHUNK_SAMPLES),
        .GAIN_MAX      (GAIN_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (out_code),
        .out_gated (out_gated),
        .out_drive (out_drive),
        .out_last  (m_tlast),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p)
    );

    // pack the result beat
    assign m_tdata    = {out_gated, out_code};
    assign m_tuser[0] = out_drive;

endmodule
